### src/assert_macros.svh
// Assertion macros used by the datapath module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define FPMW_ASSERT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpmw assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define FPMW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpmw assertion failed");

`endif

### src/fpmw_pkg.sv
// Shared types and constants of the flash page merge writer.
package fpmw_pkg;

  localparam int unsigned PAGE_HALFWORDS_DEF = 1024;
  localparam int unsigned FLASH_PAGES_DEF    = 32;

  localparam logic [15:0] ERASED_HW         = 16'hFFFF;
  localparam logic [31:0] FLASH_BASE_RST    = 32'h0800_0000;
  localparam logic [6:0]  FLASH_SIZE_KB_RST = 7'd64;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_DROP   = 2'd3
  } kind_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SIZE_KB = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_step;
    logic take;
    logic eval_apply;
    logic rd_done;
    logic scan_step;
    logic drain;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic it_read;
    logic eval_commit;
    logic scan_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

### src/fpmw_in_if.sv
// Input item channel: write and read requests.
interface fpmw_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] addr;
  logic [15:0] data;
  logic        last;

  modport source (output valid, cmd, addr, data, last, input ready);
  modport sink (input valid, cmd, addr, data, last, output ready);
endinterface

### src/fpmw_out_if.sv
// Result channel: read data, commit reports and error flags.
interface fpmw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] rdata;
  logic [4:0]  page;
  logic        erased;

  modport source (output valid, kind, rdata, page, erased, input ready);
  modport sink (input valid, kind, rdata, page, erased, output ready);
endinterface

### src/fpmw_cfg_if.sv
// Configuration write channel.
interface fpmw_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

### src/flash_page_merge_writer_top.sv
// Top level of the flash page merge writer.
// Usage:
//   in_i  carries write halfwords (cmd 0) in bursts and single reads (cmd 1);
//         the first write item of a burst gives the start byte address,
//         later items go to the following halfwords, last ends the burst.
//   out_o carries one result per read, per committed page segment, per
//         rejected burst start and per item dropped past the flash end.
//   cfg_i writes flash_base (index 0) and flash_size_kb (index 1); it is
//         always ready and takes effect from the next item.
// Sequence: an item is taken in IDLE and evaluated in EVAL. A read passes
//   through RDWAIT as well because of the registered flash read port.
//   A commit walks the whole page through the single flash port in SCAN
//   and then DRAIN, during which no item is taken.
// Reset: the store is erased by a clearing pass over all PAGE_HALFWORDS *
//   FLASH_PAGES halfwords (32768 by default) before the first item is taken.
// A stalled receiver holds the one result register; a new item can be taken
//   meanwhile, but its evaluation waits until the result has transferred.
module flash_page_merge_writer_top #(
  parameter int unsigned PAGE_HALFWORDS = fpmw_pkg::PAGE_HALFWORDS_DEF,
  parameter int unsigned FLASH_PAGES    = fpmw_pkg::FLASH_PAGES_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  fpmw_in_if.sink     in_i,
  fpmw_out_if.source  out_o,
  fpmw_cfg_if.sink    cfg_i
);
  import fpmw_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_i.ready = 1'b1;

  // Sequence the work
  fpmw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold storage and burst state
  fpmw_dp #(
    .PAGE_HALFWORDS (PAGE_HALFWORDS),
    .FLASH_PAGES    (FLASH_PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_cmd_i     (in_i.cmd),
    .in_addr_i    (in_i.addr),
    .in_data_i    (in_i.data),
    .in_last_i    (in_i.last),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_wdata_i  (cfg_i.wdata),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_kind_o   (out_o.kind),
    .out_rdata_o  (out_o.rdata),
    .out_page_o   (out_o.page),
    .out_erased_o (out_o.erased)
  );

endmodule

### src/fpmw_ctrl.sv
// Controller state machine of the flash page merge writer.
module fpmw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fpmw_pkg::ctrl_sts_t sts_i,
  output fpmw_pkg::ctrl_cmd_t cmd_o
);
  import fpmw_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EVAL   = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;

  logic [2:0] state_q, state_d;

  // Sequence clear pass, item evaluation, read completion and page commit
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!sts_i.out_busy) begin
          if (sts_i.it_read) begin
            state_d = ST_RDWAIT;
          end else begin
            cmd_o.eval_apply = 1'b1;
            state_d = sts_i.eval_commit ? ST_SCAN : ST_IDLE;
          end
        end
      end
      ST_RDWAIT: begin
        cmd_o.rd_done = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd_o.drain = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

endmodule

### src/fpmw_dp.sv
// Datapath: flash store, page buffer, segment mask, burst state and result register.
`include "assert_macros.svh"

module fpmw_dp #(
  parameter int unsigned PAGE_HALFWORDS = fpmw_pkg::PAGE_HALFWORDS_DEF,
  parameter int unsigned FLASH_PAGES    = fpmw_pkg::FLASH_PAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpmw_pkg::ctrl_cmd_t cmd_i,
  output fpmw_pkg::ctrl_sts_t sts_o,
  input  logic                in_cmd_i,
  input  logic [31:0]         in_addr_i,
  input  logic [15:0]         in_data_i,
  input  logic                in_last_i,
  input  logic                cfg_valid_i,
  input  logic [fpmw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          out_kind_o,
  output logic [15:0]         out_rdata_o,
  output logic [4:0]          out_page_o,
  output logic                out_erased_o
);
  import fpmw_pkg::*;

  // Page size must be a power of two; the block itself does not enforce this.
  localparam int unsigned OW       = $clog2(PAGE_HALFWORDS);
  localparam int unsigned PGW      = $clog2(FLASH_PAGES + 1);
  localparam int unsigned STORE_HW = PAGE_HALFWORDS * FLASH_PAGES;
  localparam int unsigned SAW      = $clog2(STORE_HW);
  localparam int unsigned LW       = (SAW + 1 > 16) ? SAW + 1 : 16;
  localparam int unsigned EW       = PGW + OW;
  localparam int unsigned CW       = ((EW > LW) ? EW : LW) + 1;
  localparam logic [LW-1:0] LIM_CAP  = LW'(STORE_HW);
  localparam logic [OW-1:0] OFF_LAST = OW'(PAGE_HALFWORDS - 1);
  localparam logic [SAW-1:0] CLR_LAST = SAW'(STORE_HW - 1);

  // Usable size in halfwords: min(kb * 512, store size)
  function automatic logic [LW-1:0] lim_of(input logic [6:0] kb);
    logic [LW-1:0] k;
    k = LW'({kb, 9'b0});
    return (k < LIM_CAP) ? k : LIM_CAP;
  endfunction

  // Memories
  logic [15:0] flash_mem [STORE_HW];
  logic [15:0] buf_mem   [PAGE_HALFWORDS];
  logic        mask_mem  [PAGE_HALFWORDS];

  logic [31:0]    base_q;
  logic [LW-1:0]  lim_q;
  logic           it_cmd_q, it_last_q;
  logic [31:0]    it_addr_q;
  logic [15:0]    it_data_q;
  logic           active_q, active_d, rej_q, rej_d;
  logic [PGW-1:0] page_q, page_d;
  logic [OW-1:0]  noff_q, noff_d;
  logic [SAW-1:0] clr_q;
  logic [OW-1:0]  scan_cnt_q, pipe_idx_q;
  logic [PGW-1:0] scan_page_q;
  logic           pipe_v_q, dirty_q;
  logic [15:0]    flash_rd_q, buf_rd_q;
  logic           mask_rd_q, rd_in_q;
  logic           out_valid_q;
  logic [1:0]     out_kind_q;
  logic [15:0]    out_rdata_q;
  logic [4:0]     out_page_q;
  logic           out_erased_q;

  logic [31:0]    off;
  logic [30:0]    pos_hw;
  logic           in_range, reject, skip, drop, store, commit, imm_res, hit;
  logic [PGW-1:0] spage, epage;
  logic [OW-1:0]  soff, eoff;
  logic [CW-1:0]  epos, lim_c;
  logic           fl_we, mask_we, mask_wd;
  logic [SAW-1:0] fl_waddr, fl_raddr;
  logic [15:0]    fl_wdata;
  logic [OW-1:0]  mask_waddr;

  // Decode the held item against the range and the burst state
  always_comb begin
    off      = it_addr_q - base_q;
    pos_hw   = off[31:1];
    in_range = (it_addr_q >= base_q) && (pos_hw < 31'(lim_q));
    spage    = PGW'(pos_hw >> OW);
    soff     = pos_hw[OW-1:0];
    epage    = active_q ? page_q : spage;
    eoff     = active_q ? noff_q : soff;
    epos     = CW'({epage, eoff});
    lim_c    = CW'(lim_q);
    reject   = !active_q && !in_range;
    skip     = active_q && rej_q;
    drop     = epos >= lim_c;
    store    = !reject && !skip && !drop;
    commit   = it_last_q || (eoff == OFF_LAST) || ((epos + CW'(1)) >= lim_c);
    imm_res  = reject || (!skip && drop);
    hit      = pipe_v_q && mask_rd_q && (flash_rd_q != ERASED_HW);
  end

  // Advance burst state on an applied write item
  always_comb begin
    active_d = active_q;
    rej_d    = rej_q;
    page_d   = page_q;
    noff_d   = noff_q;
    if (cmd_i.eval_apply) begin
      priority if (reject) begin
        active_d = !it_last_q;
        rej_d    = !it_last_q;
      end else if (skip) begin
        if (it_last_q) begin
          active_d = 1'b0;
          rej_d    = 1'b0;
        end
      end else begin
        active_d = 1'b1;
        rej_d    = 1'b0;
        page_d   = epage;
        noff_d   = eoff;
        if (store) begin
          noff_d = eoff + OW'(1);
          if (eoff == OFF_LAST) page_d = epage + PGW'(1);
        end
        if (it_last_q) active_d = 1'b0;
      end
    end
  end

  // Memory port selection
  always_comb begin
    fl_we      = cmd_i.clr_step || (pipe_v_q && mask_rd_q);
    fl_waddr   = cmd_i.clr_step ? clr_q : SAW'({scan_page_q, pipe_idx_q});
    fl_wdata   = cmd_i.clr_step ? ERASED_HW : buf_rd_q;
    fl_raddr   = cmd_i.scan_step ? SAW'({scan_page_q, scan_cnt_q}) : SAW'(pos_hw);
    mask_we    = cmd_i.clr_step || pipe_v_q || (cmd_i.eval_apply && store);
    mask_wd    = !(cmd_i.clr_step || pipe_v_q);
    mask_waddr = cmd_i.clr_step ? clr_q[OW-1:0] : (pipe_v_q ? pipe_idx_q : eoff);
  end

  // Flash store
  always_ff @(posedge clk_i) begin
    if (fl_we) flash_mem[fl_waddr] <= fl_wdata;
    flash_rd_q <= flash_mem[fl_raddr];
  end

  // Page buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_apply && store) buf_mem[eoff] <= it_data_q;
    buf_rd_q <= buf_mem[scan_cnt_q];
  end

  // Segment mask
  always_ff @(posedge clk_i) begin
    if (mask_we) mask_mem[mask_waddr] <= mask_wd;
    mask_rd_q <= mask_mem[scan_cnt_q];
  end

  // Capture the item and the read range flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      it_cmd_q  <= in_cmd_i;
      it_addr_q <= in_addr_i;
      it_data_q <= in_data_i;
      it_last_q <= in_last_i;
    end
    rd_in_q <= in_range;
  end

  // Scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_apply && store && commit) begin
      scan_cnt_q  <= '0;
      scan_page_q <= epage;
      dirty_q     <= 1'b0;
    end else begin
      if (cmd_i.scan_step) scan_cnt_q <= scan_cnt_q + OW'(1);
      if (hit) dirty_q <= 1'b1;
    end
    if (cmd_i.scan_step) pipe_idx_q <= scan_cnt_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= FLASH_BASE_RST;
      lim_q    <= lim_of(FLASH_SIZE_KB_RST);
      active_q <= 1'b0;
      rej_q    <= 1'b0;
      page_q   <= '0;
      noff_q   <= '0;
      clr_q    <= '0;
      pipe_v_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_FLASH_BASE:    base_q <= cfg_wdata_i;
          CFG_FLASH_SIZE_KB: lim_q  <= lim_of(cfg_wdata_i[6:0]);
          default:           base_q <= base_q;
        endcase
      end
      active_q <= active_d;
      rej_q    <= rej_d;
      page_q   <= page_d;
      noff_q   <= noff_d;
      if (cmd_i.clr_step) clr_q <= clr_q + SAW'(1);
      pipe_v_q <= cmd_i.scan_step;
      if ((cmd_i.eval_apply && imm_res) || cmd_i.rd_done || cmd_i.drain) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_apply && imm_res) begin
      out_kind_q   <= reject ? KIND_REJECT : KIND_DROP;
      out_rdata_q  <= '0;
      out_page_q   <= '0;
      out_erased_q <= 1'b0;
    end else if (cmd_i.rd_done) begin
      out_kind_q   <= KIND_READ;
      out_rdata_q  <= rd_in_q ? flash_rd_q : '0;
      out_page_q   <= '0;
      out_erased_q <= 1'b0;
    end else if (cmd_i.drain) begin
      out_kind_q   <= KIND_COMMIT;
      out_rdata_q  <= '0;
      out_page_q   <= 5'(scan_page_q);
      out_erased_q <= dirty_q || hit;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_rdata_o  = out_rdata_q;
  assign out_page_o   = out_page_q;
  assign out_erased_o = out_erased_q;

  assign sts_o.clr_last    = clr_q == CLR_LAST;
  assign sts_o.it_read     = it_cmd_q;
  assign sts_o.eval_commit = store && commit;
  assign sts_o.scan_last   = scan_cnt_q == OFF_LAST;
  assign sts_o.out_busy    = out_valid_q;

  `FPMW_ASSERT(a_load_free, (cmd_i.rd_done || cmd_i.drain || (cmd_i.eval_apply && imm_res)), !out_valid_q)
  `FPMW_ASSERT(a_pipe_in_scan, pipe_v_q, (cmd_i.scan_step || cmd_i.drain))
  `FPMW_ASSERT_NEXT(a_scan_drain, (cmd_i.scan_step && sts_o.scan_last), cmd_i.drain)

endmodule
